/* hdl/u8250_pkg.sv */
// Package for the 8250 UART register model: request and response types,
// opcodes, register offsets, bit positions and interrupt identification codes.
// No dependencies.
package u8250_pkg;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] reg_addr;
      logic [7:0] write_data;
      logic [7:0] rx_byte;
      logic       line_overflow;
      logic       line_parity_error;
      logic       line_framing_error;
      logic       line_break;
      logic       cts_in;
      logic       dsr_in;
      logic       ri_in;
      logic       dcd_in;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        interrupt_out;
      logic        tx_valid;
      logic [7:0]  tx_data;
      logic        break_out;
      logic        dtr_out;
      logic        rts_out;
      logic        out1_out;
      logic        out2_out;
      logic [15:0] divisor_out;
      logic [7:0]  line_control_out;
   } rsp_item_type;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_RX    = 2'd3;

   localparam logic [2:0] REG_RBR = 3'd0;
   localparam logic [2:0] REG_IER = 3'd1;
   localparam logic [2:0] REG_IIR = 3'd2;
   localparam logic [2:0] REG_LCR = 3'd3;
   localparam logic [2:0] REG_MCR = 3'd4;
   localparam logic [2:0] REG_LSR = 3'd5;
   localparam logic [2:0] REG_MSR = 3'd6;
   localparam logic [2:0] REG_SCR = 3'd7;

   localparam logic [2:0] IID_NONE  = 3'b001;
   localparam logic [2:0] IID_LINE  = 3'b110;
   localparam logic [2:0] IID_RX    = 3'b100;
   localparam logic [2:0] IID_TX    = 3'b010;
   localparam logic [2:0] IID_MODEM = 3'b000;

   localparam int IE_RX    = 0;
   localparam int IE_TX    = 1;
   localparam int IE_LINE  = 2;
   localparam int IE_MODEM = 3;

   localparam int LC_BREAK = 6;
   localparam int LC_DLAB  = 7;

   localparam int MC_DTR  = 0;
   localparam int MC_RTS  = 1;
   localparam int MC_OUT1 = 2;
   localparam int MC_OUT2 = 3;
   localparam int MC_LOOP = 4;

   localparam int LS_DR = 0;
   localparam int LS_OE = 1;
   localparam int LS_PE = 2;
   localparam int LS_FE = 3;
   localparam int LS_BI = 4;

   localparam logic [6:0] LSR_RESET = 7'h60;
   localparam logic [3:0] IER_MASK  = 4'hf;
   localparam logic [4:0] MCR_MASK  = 5'h1f;

endpackage

/* hdl/u8250_if.sv */
// Valid/ready channel interfaces for the 8250 UART register model.
// No dependencies.
interface u8250_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [2:0] reg_addr;
   logic [7:0] write_data;
   logic [7:0] rx_byte;
   logic       line_overflow;
   logic       line_parity_error;
   logic       line_framing_error;
   logic       line_break;
   logic       cts_in;
   logic       dsr_in;
   logic       ri_in;
   logic       dcd_in;

   modport source (
      output valid, opcode, reg_addr, write_data, rx_byte, line_overflow,
         line_parity_error, line_framing_error, line_break, cts_in, dsr_in,
         ri_in, dcd_in,
      input ready
   );
   modport sink (
      input valid, opcode, reg_addr, write_data, rx_byte, line_overflow,
         line_parity_error, line_framing_error, line_break, cts_in, dsr_in,
         ri_in, dcd_in,
      output ready
   );
endinterface

interface u8250_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        interrupt_out;
   logic        tx_valid;
   logic [7:0]  tx_data;
   logic        break_out;
   logic        dtr_out;
   logic        rts_out;
   logic        out1_out;
   logic        out2_out;
   logic [15:0] divisor_out;
   logic [7:0]  line_control_out;

   modport source (
      output valid, read_data, interrupt_out, tx_valid, tx_data, break_out,
         dtr_out, rts_out, out1_out, out2_out, divisor_out, line_control_out,
      input ready
   );
   modport sink (
      input valid, read_data, interrupt_out, tx_valid, tx_data, break_out,
         dtr_out, rts_out, out1_out, out2_out, divisor_out, line_control_out,
      output ready
   );
endinterface

/* hdl/u8250_regs.sv */
// UART register file: state registers and the single-pass update logic for one request.
// Depends on u8250_pkg.
module u8250_regs
   import u8250_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type rsp
);

   typedef struct packed {
      logic       raise;
      logic [7:0] msr;
   } modem_upd_type;

   logic [7:0] dll_ff, dll_in;
   logic [7:0] dlm_ff, dlm_in;
   logic [3:0] ier_ff, ier_in;
   logic [7:0] lcr_ff, lcr_in;
   logic [4:0] mcr_ff, mcr_in;
   logic [6:0] lsr_ff, lsr_in;
   logic [7:0] msr_ff, msr_in;
   logic [7:0] scr_ff, scr_in;
   logic [2:0] iir_ff, iir_in;
   logic [3:0] pend_ff, pend_in;
   logic [7:0] thr_ff, thr_in;
   logic [7:0] rbr_ff, rbr_in;
   logic       dr_ff, dr_in;
   logic       ovr_ff, ovr_in;

   function automatic modem_upd_type sample_modem(input logic [7:0] msr_i,
         input logic [4:0] mcr_i, input req_item_type it);
      modem_upd_type u;
      logic lb, cts, dsr, ri, dcd;
      lb  = mcr_i[MC_LOOP];
      cts = lb ? mcr_i[MC_RTS]  : it.cts_in;
      dsr = lb ? mcr_i[MC_DTR]  : it.dsr_in;
      ri  = lb ? mcr_i[MC_OUT1] : it.ri_in;
      dcd = lb ? mcr_i[MC_OUT2] : it.dcd_in;
      u.msr = msr_i;
      u.raise = 1'b0;
      if (u.msr[4] != cts) begin
         u.msr[4] = cts;
         u.msr[0] = 1'b1;
         u.raise = 1'b1;
      end
      if (u.msr[5] != dsr) begin
         u.msr[5] = dsr;
         u.msr[1] = 1'b1;
         u.raise = 1'b1;
      end
      if (u.msr[6] && !ri) begin
         u.msr[2] = 1'b1;
         u.raise = 1'b1;
      end
      u.msr[6] = ri;
      if (u.msr[7] != dcd) begin
         u.msr[7] = dcd;
         u.msr[3] = 1'b1;
         u.raise = 1'b1;
      end
      return u;
   endfunction

   modem_upd_type mu;
   logic          lb;
   logic          dlab;

   always_comb begin
      dll_in = dll_ff;
      dlm_in = dlm_ff;
      ier_in = ier_ff;
      lcr_in = lcr_ff;
      mcr_in = mcr_ff;
      lsr_in = lsr_ff;
      msr_in = msr_ff;
      scr_in = scr_ff;
      iir_in = iir_ff;
      pend_in = pend_ff;
      thr_in = thr_ff;
      rbr_in = rbr_ff;
      dr_in = dr_ff;
      ovr_in = ovr_ff;
      rsp = '0;
      lb = mcr_ff[MC_LOOP];
      dlab = lcr_ff[LC_DLAB];
      mu = sample_modem(msr_ff, mcr_ff, item);

      case (item.opcode)
         OP_READ: begin
            case (item.reg_addr)
               REG_RBR: begin
                  if (dlab) begin
                     rsp.read_data = dll_ff;
                  end else begin
                     rsp.read_data = lb ? thr_ff : rbr_ff;
                     dr_in = 1'b0;
                     lsr_in[LS_DR] = 1'b0;
                     pend_in[IE_RX] = 1'b0;
                     iir_in = IID_NONE;
                  end
               end
               REG_IER: rsp.read_data = dlab ? dlm_ff : {4'b0, ier_ff};
               REG_IIR: begin
                  if (iir_ff == IID_NONE) begin
                     if (pend_ff[IE_LINE]) begin
                        iir_in = IID_LINE;
                     end else if (pend_ff[IE_RX]) begin
                        iir_in = IID_RX;
                     end else if (pend_ff[IE_TX]) begin
                        iir_in = IID_TX;
                        pend_in[IE_TX] = 1'b0;
                     end else if (pend_ff[IE_MODEM]) begin
                        iir_in = IID_MODEM;
                     end
                  end else if (pend_ff == 4'b0) begin
                     iir_in = IID_NONE;
                  end
                  rsp.read_data = {5'b0, iir_in};
               end
               REG_LCR: rsp.read_data = lcr_ff;
               REG_MCR: rsp.read_data = {3'b0, mcr_ff};
               REG_LSR: begin
                  if (!lb) begin
                     if (dr_ff) begin
                        lsr_in[LS_DR] = 1'b1;
                        pend_in[IE_RX] = pend_in[IE_RX] | ier_ff[IE_RX];
                     end
                     if (item.line_overflow || ovr_ff) begin
                        ovr_in = 1'b0;
                        lsr_in[LS_OE] = 1'b1;
                     end
                     if (item.line_parity_error) lsr_in[LS_PE] = 1'b1;
                     if (item.line_framing_error) lsr_in[LS_FE] = 1'b1;
                     if (item.line_break) begin
                        lsr_in[LS_BI] = 1'b1;
                        lsr_in[LS_DR] = 1'b1;
                        thr_in = 8'h00;
                     end
                  end
                  rsp.read_data = {1'b0, lsr_in};
                  lsr_in[LS_BI:LS_OE] = 4'b0;
                  pend_in[IE_LINE] = 1'b0;
                  iir_in = IID_NONE;
               end
               REG_MSR: begin
                  rsp.read_data = mu.msr;
                  msr_in = {mu.msr[7:4], 4'b0};
                  pend_in[IE_MODEM] = 1'b0;
                  iir_in = IID_NONE;
               end
               default: rsp.read_data = scr_ff;
            endcase
         end
         OP_WRITE: begin
            case (item.reg_addr)
               REG_RBR: begin
                  if (dlab) begin
                     dll_in = item.write_data;
                  end else begin
                     if (lb) begin
                        thr_in = item.write_data;
                        if (lsr_ff[LS_DR]) ovr_in = 1'b1;
                        lsr_in[LS_DR] = 1'b1;
                        pend_in[IE_RX] = pend_in[IE_RX] | ier_ff[IE_RX];
                     end else begin
                        rsp.tx_valid = 1'b1;
                        rsp.tx_data = item.write_data;
                     end
                     pend_in[IE_TX] = ier_ff[IE_TX];
                     iir_in = IID_NONE;
                  end
               end
               REG_IER: begin
                  if (dlab) begin
                     dlm_in = item.write_data;
                  end else begin
                     ier_in = item.write_data[3:0] & IER_MASK;
                     pend_in[IE_TX] = pend_ff[IE_TX] | ier_in[IE_TX];
                  end
               end
               REG_LCR: begin
                  if ((lcr_ff[LC_BREAK] != item.write_data[LC_BREAK]) && lb
                        && item.write_data[LC_BREAK]) begin
                     lsr_in[LS_BI] = 1'b1;
                     lsr_in[LS_DR] = 1'b1;
                     pend_in[IE_LINE] = pend_ff[IE_LINE] | ier_ff[IE_LINE];
                     thr_in = 8'h00;
                  end
                  lcr_in = item.write_data;
               end
               REG_MCR: begin
                  mcr_in = item.write_data[4:0] & MCR_MASK;
                  if (mcr_in[MC_LOOP]) begin
                     mu = sample_modem(msr_ff, mcr_in, item);
                     msr_in = mu.msr;
                     pend_in[IE_MODEM] = pend_ff[IE_MODEM] | (mu.raise & ier_ff[IE_MODEM]);
                  end
               end
               REG_MSR: begin
                  msr_in = {msr_ff[7:4], item.write_data[3:0]};
                  if (msr_in[3:0] != 4'b0) begin
                     pend_in[IE_MODEM] = pend_ff[IE_MODEM] | ier_ff[IE_MODEM];
                  end
               end
               REG_SCR: scr_in = item.write_data;
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            if (ier_ff != 4'b0) begin
               if (ier_ff[IE_RX] && dr_ff && !lb) begin
                  lsr_in[LS_DR] = 1'b1;
                  pend_in[IE_RX] = 1'b1;
               end
               if (ier_ff[IE_LINE]) begin
                  if (item.line_overflow || ovr_ff) begin
                     ovr_in = 1'b0;
                     lsr_in[LS_OE] = 1'b1;
                  end
                  if (item.line_parity_error) lsr_in[LS_PE] = 1'b1;
                  if (item.line_framing_error) lsr_in[LS_FE] = 1'b1;
                  if (item.line_break) begin
                     lsr_in[LS_BI] = 1'b1;
                     lsr_in[LS_DR] = 1'b1;
                     thr_in = 8'h00;
                  end
                  if (item.line_overflow || ovr_ff || item.line_parity_error
                        || item.line_framing_error || item.line_break) begin
                     pend_in[IE_LINE] = 1'b1;
                  end
               end
               if (ier_ff[IE_MODEM] && !lb) begin
                  msr_in = mu.msr;
                  if (mu.raise) pend_in[IE_MODEM] = 1'b1;
               end
               rsp.interrupt_out = (pend_in != 4'b0) && !dlab;
            end
         end
         default: begin
            rbr_in = item.rx_byte;
            if (dr_ff) ovr_in = 1'b1;
            dr_in = 1'b1;
         end
      endcase

      if (item.opcode == OP_READ && item.reg_addr == REG_LSR && !lb) begin
         if (item.line_overflow || ovr_ff || item.line_parity_error
               || item.line_framing_error || item.line_break) begin
            pend_in[IE_LINE] = 1'b0;
         end
      end

      rsp.break_out = !mcr_in[MC_LOOP] && lcr_in[LC_BREAK];
      rsp.dtr_out = mcr_in[MC_DTR];
      rsp.rts_out = mcr_in[MC_RTS];
      rsp.out1_out = mcr_in[MC_OUT1];
      rsp.out2_out = mcr_in[MC_OUT2];
      rsp.divisor_out = {dlm_in, dll_in};
      rsp.line_control_out = lcr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dll_ff <= '0;
         dlm_ff <= '0;
         ier_ff <= '0;
         lcr_ff <= '0;
         mcr_ff <= '0;
         lsr_ff <= LSR_RESET;
         msr_ff <= '0;
         scr_ff <= '0;
         iir_ff <= IID_NONE;
         pend_ff <= '0;
         thr_ff <= '0;
         rbr_ff <= '0;
         dr_ff <= 1'b0;
         ovr_ff <= 1'b0;
      end else if (fire) begin
         dll_ff <= dll_in;
         dlm_ff <= dlm_in;
         ier_ff <= ier_in;
         lcr_ff <= lcr_in;
         mcr_ff <= mcr_in;
         lsr_ff <= lsr_in;
         msr_ff <= msr_in;
         scr_ff <= scr_in;
         iir_ff <= iir_in;
         pend_ff <= pend_in;
         thr_ff <= thr_in;
         rbr_ff <= rbr_in;
         dr_ff <= dr_in;
         ovr_ff <= ovr_in;
      end
   end

`ifndef SYNTHESIS
   a_tx_only_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp.tx_valid |-> (item.opcode == OP_WRITE && item.reg_addr == REG_RBR
         && !mcr_ff[MC_LOOP] && !lcr_ff[LC_DLAB]))
      else $error("Transmit byte produced outside a holding register write.");
   a_lsr_fixed_bits: assert property (@(posedge clock) disable iff (reset)
      lsr_ff[6:5] == 2'b11)
      else $error("Transmitter empty bits of the line status changed.");
   a_iir_code: assert property (@(posedge clock) disable iff (reset)
      iir_ff == IID_NONE || iir_ff == IID_LINE || iir_ff == IID_RX
         || iir_ff == IID_TX || iir_ff == IID_MODEM)
      else $error("Interrupt identification holds an unknown code.");
   a_lsr_read_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.opcode == OP_READ && item.reg_addr == REG_LSR |=> !pend_ff[IE_LINE])
      else $error("Line status interrupt still pending after a status read.");
   a_pend_enabled: assert property (@(posedge clock) disable iff (reset)
      fire && item.opcode == OP_RX |=> pend_ff == $past(pend_ff))
      else $error("A received byte changed the pending interrupt flags.");
`endif

endmodule

/* hdl/uart_8250_register_model.sv */
// Top level of the 8250 UART register model: request register, register file and
// response register. Depends on u8250_pkg, u8250_req_if, u8250_rsp_if and u8250_regs.
//
// Each request (register read, register write, tick or received byte) is captured
// in an input register and applied to the register file; its response is captured
// in the output register on the edge that updates the register file state. One
// request per cycle is sustained while the response channel keeps accepting. A
// waiting response does not block the next request from being captured; ready
// falls only when both stages hold undelivered requests.
module uart_8250_register_model
   import u8250_pkg::*;
(
   input  logic clock,
   input  logic reset,
   u8250_req_if.sink   req_bus,
   u8250_rsp_if.source rsp_bus
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type rsp_next;
   req_item_type req_item;
   logic         advance;
   logic         take;

   assign req_item.opcode = req_bus.opcode;
   assign req_item.reg_addr = req_bus.reg_addr;
   assign req_item.write_data = req_bus.write_data;
   assign req_item.rx_byte = req_bus.rx_byte;
   assign req_item.line_overflow = req_bus.line_overflow;
   assign req_item.line_parity_error = req_bus.line_parity_error;
   assign req_item.line_framing_error = req_bus.line_framing_error;
   assign req_item.line_break = req_bus.line_break;
   assign req_item.cts_in = req_bus.cts_in;
   assign req_item.dsr_in = req_bus.dsr_in;
   assign req_item.ri_in = req_bus.ri_in;
   assign req_item.dcd_in = req_bus.dcd_in;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;
   assign in_valid_in = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   u8250_regs u_regs (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_item_ff),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= rsp_next;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.read_data = out_item_ff.read_data;
   assign rsp_bus.interrupt_out = out_item_ff.interrupt_out;
   assign rsp_bus.tx_valid = out_item_ff.tx_valid;
   assign rsp_bus.tx_data = out_item_ff.tx_data;
   assign rsp_bus.break_out = out_item_ff.break_out;
   assign rsp_bus.dtr_out = out_item_ff.dtr_out;
   assign rsp_bus.rts_out = out_item_ff.rts_out;
   assign rsp_bus.out1_out = out_item_ff.out1_out;
   assign rsp_bus.out2_out = out_item_ff.out2_out;
   assign rsp_bus.divisor_out = out_item_ff.divisor_out;
   assign rsp_bus.line_control_out = out_item_ff.line_control_out;

`ifndef SYNTHESIS
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("Captured request lost before it was processed.");
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("Processed request produced no response.");
   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff && $stable(out_item_ff))
      else $error("Stalled response was overwritten.");
`endif

endmodule

/* tb/u8250_checker.sv */
// Checker for the 8250 UART register model: watches the request and response
// channels, predicts every response and compares it with what the block returns.
// Depends on u8250_pkg, u8250_req_if and u8250_rsp_if.
module u8250_checker
   import u8250_pkg::*;
(
   input  logic clock,
   input  logic reset,
   u8250_req_if req_bus,
   u8250_rsp_if rsp_bus,
   output int   mismatch_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MS_DCTS = 0;
   localparam int MS_DDSR = 1;
   localparam int MS_TERI = 2;
   localparam int MS_DDCD = 3;
   localparam int MS_CTS  = 4;
   localparam int MS_DSR  = 5;
   localparam int MS_RI   = 6;
   localparam int MS_DCD  = 7;

   logic [7:0] dll, dlm, lcr, lsr, msr, scr, thr, rbr;
   logic [3:0] ier, pend_flags;
   logic [4:0] mcr;
   logic [2:0] iid;
   logic       rx_ready, overrun_due;

   rsp_item_type expected_responses[$];
   int response_count;

   function automatic void clear_registers();
      dll = '0; dlm = '0; ier = '0; lcr = '0; mcr = '0;
      lsr = {1'b0, LSR_RESET}; msr = '0; scr = '0;
      iid = IID_NONE; pend_flags = '0; thr = '0; rbr = '0;
      rx_ready = 1'b0; overrun_due = 1'b0;
   endfunction

   function automatic logic looped();
      return mcr[MC_LOOP];
   endfunction

   function automatic void raise_pending(input int idx);
      pend_flags[idx] = pend_flags[idx] | ier[idx];
   endfunction

   function automatic void sample_rx();
      if (rx_ready && !looped()) begin
         lsr[LS_DR] = 1'b1;
         raise_pending(IE_RX);
      end
   endfunction

   function automatic void sample_line(input req_item_type r);
      if (r.line_overflow || overrun_due) begin
         overrun_due = 1'b0;
         lsr[LS_OE] = 1'b1;
         raise_pending(IE_LINE);
      end
      if (r.line_parity_error) begin
         lsr[LS_PE] = 1'b1;
         raise_pending(IE_LINE);
      end
      if (r.line_framing_error) begin
         lsr[LS_FE] = 1'b1;
         raise_pending(IE_LINE);
      end
      if (r.line_break) begin
         lsr[LS_BI] = 1'b1;
         lsr[LS_DR] = 1'b1;
         raise_pending(IE_LINE);
         thr = '0;
      end
   endfunction

   function automatic void track_level(input logic level, input int lvl, input int delta);
      if (msr[lvl] != level) begin
         msr[lvl] = level;
         msr[delta] = 1'b1;
         raise_pending(IE_MODEM);
      end
   endfunction

   function automatic void sample_modem(input req_item_type r);
      logic cts, dsr, ri, dcd;
      cts = looped() ? mcr[MC_RTS] : r.cts_in;
      dsr = looped() ? mcr[MC_DTR] : r.dsr_in;
      ri = looped() ? mcr[MC_OUT1] : r.ri_in;
      dcd = looped() ? mcr[MC_OUT2] : r.dcd_in;
      track_level(cts, MS_CTS, MS_DCTS);
      track_level(dsr, MS_DSR, MS_DDSR);
      if (msr[MS_RI] && !ri) begin
         msr[MS_TERI] = 1'b1;
         raise_pending(IE_MODEM);
      end
      msr[MS_RI] = ri;
      track_level(dcd, MS_DCD, MS_DDCD);
   endfunction

   function automatic logic [7:0] read_register(input req_item_type r);
      logic [7:0] value;
      logic       dlab;
      value = '0;
      dlab = lcr[LC_DLAB];
      case (r.reg_addr)
         REG_RBR: begin
            if (dlab) begin
               value = dll;
            end else begin
               value = looped() ? thr : rbr;
               rx_ready = 1'b0;
               lsr[LS_DR] = 1'b0;
               pend_flags[IE_RX] = 1'b0;
               iid = IID_NONE;
            end
         end
         REG_IER: value = dlab ? dlm : {4'b0, ier};
         REG_IIR: begin
            if (iid == IID_NONE) begin
               if (pend_flags[IE_LINE]) begin
                  iid = IID_LINE;
               end else if (pend_flags[IE_RX]) begin
                  iid = IID_RX;
               end else if (pend_flags[IE_TX]) begin
                  iid = IID_TX;
                  pend_flags[IE_TX] = 1'b0;
               end else if (pend_flags[IE_MODEM]) begin
                  iid = IID_MODEM;
               end
            end else if (pend_flags == '0) begin
               iid = IID_NONE;
            end
            value = {5'b0, iid};
         end
         REG_LCR: value = lcr;
         REG_MCR: value = {3'b0, mcr};
         REG_LSR: begin
            if (!looped()) begin
               sample_rx();
               sample_line(r);
            end
            value = lsr;
            lsr[LS_OE] = 1'b0;
            lsr[LS_PE] = 1'b0;
            lsr[LS_FE] = 1'b0;
            lsr[LS_BI] = 1'b0;
            pend_flags[IE_LINE] = 1'b0;
            iid = IID_NONE;
         end
         REG_MSR: begin
            sample_modem(r);
            value = msr;
            msr = msr & 8'hf0;
            pend_flags[IE_MODEM] = 1'b0;
            iid = IID_NONE;
         end
         default: value = scr;
      endcase
      return value;
   endfunction

   function automatic void write_register(input req_item_type r, inout rsp_item_type e);
      logic [7:0] v;
      logic       dlab;
      v = r.write_data;
      dlab = lcr[LC_DLAB];
      case (r.reg_addr)
         REG_RBR: begin
            if (dlab) begin
               dll = v;
            end else begin
               if (looped()) begin
                  thr = v;
                  if (lsr[LS_DR]) overrun_due = 1'b1;
                  lsr[LS_DR] = 1'b1;
                  raise_pending(IE_RX);
               end else begin
                  e.tx_valid = 1'b1;
                  e.tx_data = v;
               end
               pend_flags[IE_TX] = 1'b0;
               iid = IID_NONE;
               raise_pending(IE_TX);
            end
         end
         REG_IER: begin
            if (dlab) begin
               dlm = v;
            end else begin
               ier = v[3:0] & IER_MASK;
               raise_pending(IE_TX);
            end
         end
         REG_LCR: begin
            if ((lcr[LC_BREAK] != v[LC_BREAK]) && looped() && v[LC_BREAK]) begin
               lsr[LS_BI] = 1'b1;
               lsr[LS_DR] = 1'b1;
               raise_pending(IE_LINE);
               thr = '0;
            end
            lcr = v;
         end
         REG_MCR: begin
            mcr = v[4:0] & MCR_MASK;
            if (looped()) sample_modem(r);
         end
         REG_MSR: begin
            msr = {msr[7:4], v[3:0]};
            if (msr[3:0] != '0) raise_pending(IE_MODEM);
         end
         REG_SCR: scr = v;
         default: ;
      endcase
   endfunction

   function automatic rsp_item_type predict_response(input req_item_type r);
      rsp_item_type e;
      e = '0;
      case (r.opcode)
         OP_READ: e.read_data = read_register(r);
         OP_WRITE: write_register(r, e);
         OP_TICK: begin
            if (ier != '0) begin
               if (ier[IE_RX]) sample_rx();
               if (ier[IE_LINE]) sample_line(r);
               if (ier[IE_MODEM] && !looped()) sample_modem(r);
               if (pend_flags != '0 && !lcr[LC_DLAB]) e.interrupt_out = 1'b1;
            end
         end
         default: begin
            rbr = r.rx_byte;
            if (rx_ready) overrun_due = 1'b1;
            rx_ready = 1'b1;
         end
      endcase
      e.break_out = !looped() && lcr[LC_BREAK];
      e.dtr_out = mcr[MC_DTR];
      e.rts_out = mcr[MC_RTS];
      e.out1_out = mcr[MC_OUT1];
      e.out2_out = mcr[MC_OUT2];
      e.divisor_out = {dlm, dll};
      e.line_control_out = lcr;
      return e;
   endfunction

   function automatic string describe(input rsp_item_type x);
      return $sformatf("rd=%h irq=%b txv=%b txd=%h brk=%b mcr=%b%b%b%b div=%h lcr=%h",
         x.read_data, x.interrupt_out, x.tx_valid, x.tx_data, x.break_out, x.out2_out,
         x.out1_out, x.rts_out, x.dtr_out, x.divisor_out, x.line_control_out);
   endfunction

   always @(posedge clock) begin : watch
      req_item_type req;
      rsp_item_type got, want;
      if (reset) begin
         clear_registers();
         expected_responses.delete();
         response_count = 0;
         outstanding <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            req = {req_bus.opcode, req_bus.reg_addr, req_bus.write_data, req_bus.rx_byte,
               req_bus.line_overflow, req_bus.line_parity_error, req_bus.line_framing_error,
               req_bus.line_break, req_bus.cts_in, req_bus.dsr_in, req_bus.ri_in,
               req_bus.dcd_in};
            expected_responses.push_back(predict_response(req));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.read_data, rsp_bus.interrupt_out, rsp_bus.tx_valid,
               rsp_bus.tx_data, rsp_bus.break_out, rsp_bus.dtr_out, rsp_bus.rts_out,
               rsp_bus.out1_out, rsp_bus.out2_out, rsp_bus.divisor_out,
               rsp_bus.line_control_out};
            if (expected_responses.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("Response %0d arrived with nothing expected: %s",
                     response_count, describe(got));
            end else begin
               want = expected_responses.pop_front();
               if (got !== want) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("Response %0d mismatch: expected %s, got %s",
                        response_count, describe(want), describe(got));
               end
            end
            response_count = response_count + 1;
         end
         outstanding <= expected_responses.size();
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the 8250 UART register model testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on u8250_pkg, the channel interfaces, the block and u8250_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import u8250_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 181;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   quiet_cycles;
   int   send_idle_by_phase[4] = '{0, 46, 0, 21};
   int   recv_stall_by_phase[4] = '{0, 0, 46, 21};

   u8250_req_if req_bus();
   u8250_rsp_if rsp_bus();

   uart_8250_register_model dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   u8250_checker register_checker (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_item_type make_request(input logic [1:0] op, input logic [2:0] addr,
         input logic [7:0] data, input logic [7:0] rx, input logic [3:0] line,
         input logic [3:0] modem);
      return {op, addr, data, rx, line, modem};
   endfunction

   function automatic req_item_type random_request();
      req_item_type r;
      int           pick;
      pick = $urandom_range(99);
      r.opcode = (pick < 36) ? OP_READ : (pick < 72) ? OP_WRITE : (pick < 86) ? OP_TICK : OP_RX;
      r.reg_addr = 3'($urandom_range(7));
      r.write_data = 8'($urandom_range(255));
      r.rx_byte = 8'($urandom_range(255));
      r.line_overflow = ($urandom_range(7) == 0);
      r.line_parity_error = ($urandom_range(7) == 0);
      r.line_framing_error = ($urandom_range(7) == 0);
      r.line_break = ($urandom_range(7) == 0);
      r.cts_in = 1'($urandom_range(1));
      r.dsr_in = 1'($urandom_range(1));
      r.ri_in = 1'($urandom_range(1));
      r.dcd_in = 1'($urandom_range(1));
      if (r.opcode == OP_WRITE && r.reg_addr == REG_LCR)
         r.write_data[LC_DLAB] = ($urandom_range(3) == 0);
      if (r.opcode == OP_WRITE && r.reg_addr == REG_MCR)
         r.write_data[MC_LOOP] = ($urandom_range(9) < 3);
      return r;
   endfunction

   task automatic send_request(input req_item_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      {req_bus.opcode, req_bus.reg_addr, req_bus.write_data, req_bus.rx_byte,
         req_bus.line_overflow, req_bus.line_parity_error, req_bus.line_framing_error,
         req_bus.line_break, req_bus.cts_in, req_bus.dsr_in, req_bus.ri_in,
         req_bus.dcd_in} <= r;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_bus.valid = 1'b0;
      {req_bus.opcode, req_bus.reg_addr, req_bus.write_data, req_bus.rx_byte,
         req_bus.line_overflow, req_bus.line_parity_error, req_bus.line_framing_error,
         req_bus.line_break, req_bus.cts_in, req_bus.dsr_in, req_bus.ri_in,
         req_bus.dcd_in} = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The divisor latch is banked behind DLAB; the loopback part covers the break
      // and overrun paths, and the transmit-ident path follows once loopback is off.
      send_request(make_request(OP_WRITE, REG_LCR, 8'h80, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_RBR, 8'hff, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_IER, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_READ, REG_RBR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_LCR, 8'h3f, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_IER, 8'hff, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_SCR, 8'hff, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_READ, REG_SCR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_RX, REG_RBR, 8'h00, 8'ha5, 4'hf, 4'hf));
      send_request(make_request(OP_RX, REG_RBR, 8'h00, 8'h5a, 4'h0, 4'h0));
      send_request(make_request(OP_TICK, REG_RBR, 8'h00, 8'h00, 4'hf, 4'hf));
      send_request(make_request(OP_READ, REG_IIR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_READ, REG_LSR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_READ, REG_RBR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_READ, REG_MSR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_MCR, 8'hff, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_LCR, 8'h40, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_RBR, 8'hff, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_READ, REG_LSR, 8'h00, 8'h00, 4'hf, 4'h0));
      send_request(make_request(OP_READ, REG_RBR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_MCR, 8'h00, 8'h00, 4'h0, 4'hf));
      send_request(make_request(OP_WRITE, REG_MSR, 8'h0f, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_IIR, 8'hff, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_LSR, 8'hff, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_WRITE, REG_RBR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_READ, REG_IIR, 8'h00, 8'h00, 4'h0, 4'h0));
      send_request(make_request(OP_TICK, REG_RBR, 8'h00, 8'h00, 4'h0, 4'h0));

      for (int phase = 0; phase < 8; phase++) begin
         send_idle_pct = send_idle_by_phase[phase % 4];
         recv_stall_pct = recv_stall_by_phase[phase % 4];
         repeat (PHASE_ITEMS) send_request(random_request());
      end
      req_bus.valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

/* files.f */
hdl/u8250_pkg.sv
hdl/u8250_if.sv
hdl/u8250_regs.sv
hdl/uart_8250_register_model.sv
tb/u8250_checker.sv
tb/testbench.sv
